[rtl/tccs_pkg.sv]
// shared types and constants for the text console cursor and scroll engine
package tccs_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS = 25;

   localparam logic [7:0] BLANK_ATTR_RESET = 8'd7;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef enum logic [1:0] {
      FUNC_PUT = 2'd0,
      FUNC_SET = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep;
      logic sweep_scroll;
      logic sweep_init;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic needs_scroll;
      logic sweep_last;
      logic wr_pend;
   } status_type;

endpackage

[rtl/tccs_ctrl.sv]
// command sequencer and response handshake for the console engine
module tccs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  tccs_pkg::status_type status,
   output tccs_pkg::cmd_type cmd
);

   tccs_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         tccs_pkg::ST_INIT: begin
            cmd.sweep = 1'b1;
            cmd.sweep_init = 1'b1;
            if (status.sweep_last) begin
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_IDLE: begin
            req_ready = !status.wr_pend;
            if (req_valid && !status.wr_pend) begin
               cmd.capture = 1'b1;
               state_in = tccs_pkg::ST_EXEC;
            end
         end
         tccs_pkg::ST_EXEC: begin
            priority if (status.func == tccs_pkg::FUNC_CLEAR) begin
               cmd.exec = 1'b1;
               state_in = tccs_pkg::ST_CLEAR;
            end else if (status.needs_scroll) begin
               cmd.exec = 1'b1;
               state_in = tccs_pkg::ST_SCROLL;
            end else if (out_free) begin
               cmd.exec = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         tccs_pkg::ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = tccs_pkg::ST_RESP;
            end
         end
         tccs_pkg::ST_SCROLL: begin
            cmd.sweep = 1'b1;
            cmd.sweep_scroll = 1'b1;
            if (status.sweep_last) begin
               state_in = tccs_pkg::ST_RESP;
            end
         end
         tccs_pkg::ST_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = tccs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tccs_pkg::ST_INIT;
         end
      endcase
   end

endmodule

[rtl/tccs_datapath.sv]
// cell store, cursor, sweep engine and response registers of the console engine
module tccs_datapath #(
   parameter int COLUMNS = tccs_pkg::DEFAULT_COLUMNS,
   parameter int ROWS = tccs_pkg::DEFAULT_ROWS
) (
   input  logic clock,
   input  logic reset,
   input  tccs_pkg::cmd_type cmd,
   output tccs_pkg::status_type status,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_attribute,
   input  logic [7:0] req_col,
   input  logic [7:0] req_row,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output logic [6:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row,
   output logic [11:0] rsp_cursor_offset,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attr,
   output logic rsp_scrolled
);

   localparam int Cells = COLUMNS * ROWS;
   localparam int ColW = $clog2(COLUMNS);
   localparam int RowW = $clog2(ROWS);
   localparam int IdxW = $clog2(Cells);
   localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);
   localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
   localparam logic [IdxW-1:0] LastRowIdx = IdxW'((ROWS - 1) * COLUMNS);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(Cells - 1);
   localparam logic [IdxW-1:0] ColStep = IdxW'(COLUMNS);

   logic [15:0] mem [Cells];
   logic [15:0] rd_data_ff;
   logic rd_en;
   logic [IdxW-1:0] rd_addr;
   logic wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [15:0] wr_data;

   logic [7:0] blank_attr_ff;
   logic [15:0] blank_cell;
   logic [15:0] sweep_blank;

   tccs_pkg::func_type func_ff;
   logic [7:0] char_ff, attr_ff;
   logic [ColW-1:0] set_col_ff;
   logic [RowW-1:0] set_row_ff;
   logic [IdxW-1:0] set_idx_ff;

   logic [ColW-1:0] req_col_clamp;
   logic [RowW-1:0] req_row_clamp;
   logic [IdxW-1:0] req_idx;

   logic [ColW-1:0] cur_col_ff, cur_col_in;
   logic [RowW-1:0] cur_row_ff, cur_row_in;
   logic [IdxW-1:0] cur_idx_ff, cur_idx_in;
   logic needs_scroll;
   logic put_wr;
   logic [IdxW-1:0] put_addr;
   logic [15:0] put_data;
   logic at_last_col, at_last_row;

   logic [IdxW-1:0] cnt_ff;
   logic copy_region;
   logic sw_pend_ff;
   logic [IdxW-1:0] sw_addr_ff;
   logic sw_blank_ff, sw_init_ff;

   logic scrolled_ff, scrolled_in;
   logic [31:0] col_ext, row_ext, off_ext;

   logic [6:0] rsp_col_ff;
   logic [4:0] rsp_row_ff;
   logic [11:0] rsp_off_ff;
   logic [7:0] rsp_char_ff, rsp_attr_ff;
   logic rsp_scr_ff;

   // request decode and clamping
   assign req_col_clamp = ({1'b0, req_col} >= 9'(COLUMNS)) ? LastCol : req_col[ColW-1:0];
   assign req_row_clamp = ({1'b0, req_row} >= 9'(ROWS)) ? LastRow : req_row[RowW-1:0];
   assign req_idx = IdxW'(32'(req_row_clamp) * COLUMNS + 32'(req_col_clamp));

   assign blank_cell = {blank_attr_ff, tccs_pkg::CH_SPACE};
   assign sweep_blank = {(sw_init_ff ? tccs_pkg::BLANK_ATTR_RESET : blank_attr_ff),
                         tccs_pkg::CH_SPACE};

   assign at_last_col = cur_col_ff == LastCol;
   assign at_last_row = cur_row_ff == LastRow;
   assign copy_region = cnt_ff < IdxW'(Cells - COLUMNS);

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      cur_idx_in = cur_idx_ff;
      needs_scroll = 1'b0;
      put_wr = 1'b0;
      put_addr = cur_idx_ff;
      put_data = {attr_ff, char_ff};
      unique case (func_ff)
         tccs_pkg::FUNC_PUT: begin
            priority if (char_ff == tccs_pkg::CH_NEWLINE) begin
               cur_col_in = '0;
               if (at_last_row) begin
                  needs_scroll = 1'b1;
                  cur_idx_in = LastRowIdx;
               end else begin
                  cur_row_in = cur_row_ff + RowW'(1);
                  cur_idx_in = cur_idx_ff - IdxW'(cur_col_ff) + ColStep;
               end
            end else if (char_ff == tccs_pkg::CH_RETURN) begin
               cur_col_in = '0;
               cur_idx_in = cur_idx_ff - IdxW'(cur_col_ff);
            end else if (char_ff == tccs_pkg::CH_BACKSPACE) begin
               put_addr = cur_idx_ff - IdxW'(1);
               put_data = blank_cell;
               if (cur_col_ff != '0) begin
                  put_wr = 1'b1;
                  cur_col_in = cur_col_ff - ColW'(1);
                  cur_idx_in = cur_idx_ff - IdxW'(1);
               end else if (cur_row_ff != '0) begin
                  put_wr = 1'b1;
                  cur_col_in = LastCol;
                  cur_row_in = cur_row_ff - RowW'(1);
                  cur_idx_in = cur_idx_ff - IdxW'(1);
               end
            end else begin
               put_wr = 1'b1;
               if (at_last_col) begin
                  cur_col_in = '0;
                  if (at_last_row) begin
                     needs_scroll = 1'b1;
                     cur_idx_in = LastRowIdx;
                  end else begin
                     cur_row_in = cur_row_ff + RowW'(1);
                     cur_idx_in = cur_idx_ff + IdxW'(1);
                  end
               end else begin
                  cur_col_in = cur_col_ff + ColW'(1);
                  cur_idx_in = cur_idx_ff + IdxW'(1);
               end
            end
         end
         tccs_pkg::FUNC_SET: begin
            cur_col_in = set_col_ff;
            cur_row_in = set_row_ff;
            cur_idx_in = set_idx_ff;
         end
         tccs_pkg::FUNC_READ: begin
         end
         tccs_pkg::FUNC_CLEAR: begin
            cur_col_in = '0;
            cur_row_in = '0;
            cur_idx_in = '0;
         end
         default: begin
         end
      endcase
      if (!cmd.exec) begin
         cur_col_in = cur_col_ff;
         cur_row_in = cur_row_ff;
         cur_idx_in = cur_idx_ff;
      end
   end

   // memory ports
   assign rd_en = cmd.capture || (cmd.sweep && cmd.sweep_scroll && copy_region);
   assign rd_addr = cmd.capture ? req_idx : cnt_ff + ColStep;
   assign wr_en = sw_pend_ff || (cmd.exec && put_wr);
   assign wr_addr = sw_pend_ff ? sw_addr_ff : put_addr;
   assign wr_data = sw_pend_ff ? (sw_blank_ff ? sweep_blank : rd_data_ff) : put_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= tccs_pkg::BLANK_ATTR_RESET;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         cur_idx_ff <= '0;
         cnt_ff <= '0;
         sw_pend_ff <= 1'b0;
         scrolled_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blank_attr_ff <= csr_wr_data;
         end
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         cur_idx_ff <= cur_idx_in;
         if (cmd.sweep && cnt_ff != LastIdx) begin
            cnt_ff <= cnt_ff + IdxW'(1);
         end else begin
            cnt_ff <= '0;
         end
         sw_pend_ff <= cmd.sweep;
         scrolled_ff <= scrolled_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sw_addr_ff <= cnt_ff;
      sw_blank_ff <= !(cmd.sweep_scroll && copy_region);
      sw_init_ff <= cmd.sweep_init;
      if (cmd.capture) begin
         func_ff <= tccs_pkg::func_type'(req_func);
         char_ff <= req_char_code;
         attr_ff <= req_attribute;
         set_col_ff <= req_col_clamp;
         set_row_ff <= req_row_clamp;
         set_idx_ff <= req_idx;
      end
      if (cmd.load_rsp) begin
         rsp_col_ff <= col_ext[6:0];
         rsp_row_ff <= row_ext[4:0];
         rsp_off_ff <= off_ext[11:0];
         rsp_char_ff <= (func_ff == tccs_pkg::FUNC_READ) ? rd_data_ff[7:0] : 8'd0;
         rsp_attr_ff <= (func_ff == tccs_pkg::FUNC_READ) ? rd_data_ff[15:8] : 8'd0;
         rsp_scr_ff <= scrolled_in;
      end
   end

   assign scrolled_in = cmd.exec ? needs_scroll : scrolled_ff;
   assign col_ext = 32'(cur_col_in);
   assign row_ext = 32'(cur_row_in);
   assign off_ext = 32'(cur_idx_in) << 1;

   assign status.func = func_ff;
   assign status.needs_scroll = needs_scroll;
   assign status.sweep_last = cnt_ff == LastIdx;
   assign status.wr_pend = sw_pend_ff;

   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_offset = rsp_off_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_cell_attr = rsp_attr_ff;
   assign rsp_scrolled = rsp_scr_ff;

endmodule

[rtl/text_console_cursor_scroll_core.sv]
// top level of the text console engine: command sequencer and cell datapath
//
//   port group   direction   contents
//   req_*        in          command word: func, char_code, attribute, col, row
//   rsp_*        out         result word: cursor position, offset, read cell, scrolled
//   csr_*        in          blank attribute register write
//
// a command is accepted and reads its addressed cell, then executes and writes the cell store
// clear and scroll then add a walk over all ROWS*COLUMNS cells, one cell per cycle,
// and a response state
// after reset a clearing pass holds req_ready low
// a result held by rsp_ready low lets the next command be accepted; its own result waits
module text_console_cursor_scroll_core #(
   parameter int COLUMNS = tccs_pkg::DEFAULT_COLUMNS,
   parameter int ROWS = tccs_pkg::DEFAULT_ROWS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic [7:0] req_attribute,
   input  logic [7:0] req_col,
   input  logic [7:0] req_row,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [6:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row,
   output logic [11:0] rsp_cursor_offset,
   output logic [7:0] rsp_cell_char,
   output logic [7:0] rsp_cell_attr,
   output logic rsp_scrolled,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   tccs_pkg::cmd_type cmd;
   tccs_pkg::status_type status;

   tccs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status(status),
      .cmd(cmd)
   );

   tccs_datapath #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .req_attribute(req_attribute),
      .req_col(req_col),
      .req_row(req_row),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_cell_char(rsp_cell_char),
      .rsp_cell_attr(rsp_cell_attr),
      .rsp_scrolled(rsp_scrolled)
   );

endmodule

[tb/testbench.sv]
// testbench for the text console engine: commands against a cell store model with scoreboard
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = tccs_pkg::DEFAULT_COLUMNS;
   localparam int ROWS = tccs_pkg::DEFAULT_ROWS;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int PHASE_WORDS = 215;

   typedef struct {
      tccs_pkg::func_type func;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic [7:0] col;
      logic [7:0] row;
   } console_cmd_type;

   typedef struct packed {
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic [11:0] cursor_offset;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic scrolled;
   } console_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_attribute = '0;
   logic [7:0] req_col = '0;
   logic [7:0] req_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_cursor_col;
   logic [4:0] rsp_cursor_row;
   logic [11:0] rsp_cursor_offset;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attr;
   logic rsp_scrolled;
   logic csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // screen model
   logic [15:0] screen_model [CELLS];
   int unsigned model_col;
   int unsigned model_row;
   logic [7:0] model_blank_attr;

   console_result_type pending_results[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int mismatch_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int scroll_count = 0;
   int clear_count = 0;
   int read_count = 0;
   int attr_settings = 0;

   text_console_cursor_scroll_core #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .req_attribute(req_attribute),
      .req_col(req_col),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_cell_char(rsp_cell_char),
      .rsp_cell_attr(rsp_cell_attr),
      .rsp_scrolled(rsp_scrolled),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = {model_blank_attr, tccs_pkg::CH_SPACE};
      model_col = 0;
      model_row = 0;
   endfunction

   function automatic logic advance_line();
      model_col = 0;
      model_row++;
      if (model_row < ROWS) return 1'b0;
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen_model[i] = {model_blank_attr, tccs_pkg::CH_SPACE};
      model_row = ROWS - 1;
      scroll_count++;
      return 1'b1;
   endfunction

   function automatic console_result_type execute_console_cmd(console_cmd_type cmd);
      console_result_type res;
      int unsigned c;
      int unsigned r;
      logic [15:0] stored;
      res = '0;
      c = (cmd.col >= COLUMNS) ? COLUMNS - 1 : cmd.col;
      r = (cmd.row >= ROWS) ? ROWS - 1 : cmd.row;
      case (cmd.func)
         tccs_pkg::FUNC_PUT: begin
            if (cmd.char_code == tccs_pkg::CH_NEWLINE) begin
               res.scrolled = advance_line();
            end else if (cmd.char_code == tccs_pkg::CH_RETURN) begin
               model_col = 0;
            end else if (cmd.char_code == tccs_pkg::CH_BACKSPACE) begin
               if (model_col > 0) begin
                  model_col--;
                  screen_model[model_row * COLUMNS + model_col] =
                     {model_blank_attr, tccs_pkg::CH_SPACE};
               end else if (model_row > 0) begin
                  model_row--;
                  model_col = COLUMNS - 1;
                  screen_model[model_row * COLUMNS + model_col] =
                     {model_blank_attr, tccs_pkg::CH_SPACE};
               end
            end else begin
               screen_model[model_row * COLUMNS + model_col] = {cmd.attribute, cmd.char_code};
               model_col++;
               if (model_col >= COLUMNS) res.scrolled = advance_line();
            end
         end
         tccs_pkg::FUNC_SET: begin
            model_col = c;
            model_row = r;
         end
         tccs_pkg::FUNC_READ: begin
            stored = screen_model[r * COLUMNS + c];
            res.cell_char = stored[7:0];
            res.cell_attr = stored[15:8];
            read_count++;
         end
         default: begin
            blank_screen();
            clear_count++;
         end
      endcase
      res.cursor_col = 7'(model_col);
      res.cursor_row = 5'(model_row);
      res.cursor_offset = 12'((model_row * COLUMNS + model_col) * 2);
      return res;
   endfunction

   function automatic console_cmd_type make_cmd(tccs_pkg::func_type f, logic [7:0] ch,
                                                logic [7:0] attr, logic [7:0] col,
                                                logic [7:0] row);
      console_cmd_type cmd;
      cmd.func = f;
      cmd.char_code = ch;
      cmd.attribute = attr;
      cmd.col = col;
      cmd.row = row;
      return cmd;
   endfunction

   function automatic console_cmd_type random_command();
      console_cmd_type cmd;
      int roll;
      roll = $urandom_range(99);
      cmd = make_cmd(tccs_pkg::FUNC_PUT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
      if (roll < 55) begin
         cmd.func = tccs_pkg::FUNC_PUT;
      end else if (roll < 63) begin
         cmd.char_code = tccs_pkg::CH_NEWLINE;
      end else if (roll < 67) begin
         cmd.char_code = tccs_pkg::CH_RETURN;
      end else if (roll < 73) begin
         cmd.char_code = tccs_pkg::CH_BACKSPACE;
      end else if (roll < 82) begin
         cmd.func = tccs_pkg::FUNC_SET;
         if ($urandom_range(1)) cmd.col = 8'($urandom_range(COLUMNS - 1));
         case ($urandom_range(3))
            0: cmd.row = 8'(ROWS - 1);
            1: cmd.row = 8'($urandom_range(ROWS - 1));
            default: ;
         endcase
      end else if (roll < 98) begin
         cmd.func = tccs_pkg::FUNC_READ;
         if ($urandom_range(3) != 0) begin
            cmd.col = 8'($urandom_range(COLUMNS - 1));
            cmd.row = 8'($urandom_range(ROWS - 1));
         end
      end else begin
         cmd.func = tccs_pkg::FUNC_CLEAR;
      end
      return cmd;
   endfunction

   // offer one word and record its expected result on acceptance
   task automatic send_word(input console_cmd_type cmd);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= cmd.func;
      req_char_code <= cmd.char_code;
      req_attribute <= cmd.attribute;
      req_col <= cmd.col;
      req_row <= cmd.row;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(execute_console_cmd(cmd));
      words_sent++;
   endtask

   task automatic wait_until_idle(input int settle);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_blank_attribute(input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_blank_attr = value;
      attr_settings++;
   endtask

   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on word %0d, %s: expected %0d, got %0d",
                     words_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      console_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result word with no command outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("cursor_col", want.cursor_col, rsp_cursor_col);
            check_field("cursor_row", want.cursor_row, rsp_cursor_row);
            check_field("cursor_offset", want.cursor_offset, rsp_cursor_offset);
            check_field("cell_char", want.cell_char, rsp_cell_char);
            check_field("cell_attr", want.cell_attr, rsp_cell_attr);
            check_field("scrolled", want.scrolled, rsp_scrolled);
         end
         words_checked++;
      end
   end

   task automatic test_reset_state();
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'd0));
   endtask

   task automatic test_controls_and_wrap();
      send_word(make_cmd(tccs_pkg::FUNC_PUT, 8'h41, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, 8'h00, 8'h80, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, tccs_pkg::CH_BACKSPACE, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'd2, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, tccs_pkg::CH_RETURN, 8'h00, 8'd0, 8'd0));
      // backspace at the origin changes nothing
      send_word(make_cmd(tccs_pkg::FUNC_PUT, tccs_pkg::CH_BACKSPACE, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_SET, 8'h00, 8'h00, 8'hFF, 8'd0));
      // wrap from the last column, then backspace across the line start
      send_word(make_cmd(tccs_pkg::FUNC_PUT, 8'h5A, 8'h3C, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, tccs_pkg::CH_BACKSPACE, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_SET, 8'h00, 8'h00, 8'd3, 8'hFF));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, tccs_pkg::CH_NEWLINE, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_SET, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 1)));
      send_word(make_cmd(tccs_pkg::FUNC_PUT, 8'h78, 8'hA5, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'(COLUMNS - 1), 8'(ROWS - 2)));
      send_word(make_cmd(tccs_pkg::FUNC_CLEAR, 8'h00, 8'h00, 8'd0, 8'd0));
      send_word(make_cmd(tccs_pkg::FUNC_READ, 8'h00, 8'h00, 8'd0, 8'd0));
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input logic [7:0] blank_attr, input int count);
      wait_until_idle(4);
      write_blank_attribute(blank_attr);
      req_idle_pct = send_pct;
      rsp_stall_pct = recv_pct;
      repeat (count) send_word(random_command());
   endtask

   task automatic test_output_backpressure();
      wait_until_idle(0);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 80;
      repeat (16) send_word(random_command());
      // sender stops until every result is back
      wait_until_idle(0);
      repeat (6) send_word(random_command());
   endtask

   initial begin
      model_blank_attr = tccs_pkg::BLANK_ATTR_RESET;
      blank_screen();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_ready);

      test_reset_state();
      test_controls_and_wrap();
      test_random_phase(0, 0, 8'h00, PHASE_WORDS);
      test_random_phase(62, 0, 8'hFF, PHASE_WORDS);
      test_random_phase(0, 62, 8'($urandom_range(255)), PHASE_WORDS);
      test_random_phase(33, 33, tccs_pkg::BLANK_ATTR_RESET, PHASE_WORDS);
      test_output_backpressure();

      wait_until_idle(20);
      $display("%0d commands checked: %0d scrolls, %0d clears, %0d cell reads",
               words_checked, scroll_count, clear_count, read_count);
      $display("%0d blank attribute settings, four idle/stall mixes plus a long output stall",
               attr_settings);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
rtl/tccs_pkg.sv
rtl/tccs_ctrl.sv
rtl/tccs_datapath.sv
rtl/text_console_cursor_scroll_core.sv
tb/testbench.sv
